>>> hw/rtl/fce_pkg.sv
// Package: shared constants, codes and FAT value look-ups for the extent builder.
package fce_pkg;

    localparam int unsigned CLU_W   = 28;
    localparam int unsigned ENTRY_W = 32;
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned LOG2_W  = 5;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned COVER_W = CLU_W + (1 << LOG2_W) - 1;

    localparam logic [CLU_W-1:0] CLU_MAX = 28'hFFF_FFFF;

    typedef enum logic [1:0] {
        OUT_RUN      = 2'd0,
        OUT_FINAL    = 2'd1,
        OUT_BADENTRY = 2'd2,
        OUT_SHORT    = 2'd3
    } t_outcome;

    typedef enum logic [IDX_W-1:0] {
        REG_FAT_KIND      = 2'd0,
        REG_START_CLUSTER = 2'd1,
        REG_FILE_BYTES    = 2'd2,
        REG_CLUSTER_LOG2  = 2'd3
    } t_reg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_FAT12 = 2'd0,
        KIND_FAT16 = 2'd1,
        KIND_FAT32 = 2'd2,
        KIND_RSVD  = 2'd3
    } t_fat_kind;

    localparam logic [KIND_W-1:0] KIND_RESET    = 2'd2;
    localparam logic [CLU_W-1:0]  START_RESET   = 28'd2;
    localparam logic [SIZE_W-1:0] SIZE_RESET    = 32'd0;
    localparam logic [LOG2_W-1:0] LOG2_RESET    = 5'd12;

    function automatic logic [CLU_W-1:0] end_value(input logic [KIND_W-1:0] kind);
        logic [CLU_W-1:0] val;
        unique case (t_fat_kind'(kind))
            KIND_FAT12: val = 28'h000_0FF8;
            KIND_FAT16: val = 28'h000_FFF8;
            KIND_FAT32: val = 28'hFFF_FFF8;
            KIND_RSVD:  val = 28'hFFF_FFF8;
            default:    val = 28'hFFF_FFF8;
        endcase
        return val;
    endfunction

    function automatic logic [CLU_W-1:0] bad_value(input logic [KIND_W-1:0] kind);
        logic [CLU_W-1:0] val;
        unique case (t_fat_kind'(kind))
            KIND_FAT12: val = 28'h000_0FF7;
            KIND_FAT16: val = 28'h000_FFF7;
            KIND_FAT32: val = 28'hFFF_FFF7;
            KIND_RSVD:  val = 28'hFFF_FFF7;
            default:    val = 28'hFFF_FFF7;
        endcase
        return val;
    endfunction

endpackage

>>> hw/rtl/fat_chain_extent_builder_top.sv
// Top level: FAT cluster chain walker that emits runs of consecutive clusters.
//
// One FAT entry word is taken per cycle on the slave stream unless a result is
// held waiting on the master side; each entry is classified in a single pass
// between the input register and the result register, so the sustained rate
// is one entry per cycle while results are taken. A result waiting for the
// master side holds the entry behind it. An entry yields at most one result
// word: a finished run when the chain jumps, the final run at end of chain,
// or an error (bad/free/reserved entry, or chain shorter than the file) with
// zero offset and cluster. After a final run or an error the next entry
// starts a new walk at the start cluster. The user must write registers through
// the plain write port while no entry is in flight; the block does not enforce it.
module fat_chain_extent_builder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [fce_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [fce_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [31:0]                  i_s_axis_tdata,  // [31:0] table_entry
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [55:0]                  o_m_axis_tdata,  // [27:0] run_offset, [55:28] run_cluster
    output logic [1:0]                   o_m_axis_tuser   // [1:0] outcome
);

    localparam int unsigned CW = fce_pkg::CLU_W;

    logic [fce_pkg::KIND_W-1:0] r_fat_kind;
    logic [CW-1:0]              r_start_cluster;
    logic [fce_pkg::SIZE_W-1:0] r_file_bytes;
    logic [fce_pkg::LOG2_W-1:0] r_log2;

    logic                        r_in_valid;
    logic [fce_pkg::ENTRY_W-1:0] r_in_entry;

    logic [CW-1:0] r_walk_cluster, n_walk_cluster;
    logic [CW-1:0] r_clusters_seen, n_clusters_seen;
    logic [CW-1:0] r_run_offset, n_run_offset;
    logic [CW-1:0] r_run_cluster, n_run_cluster;
    logic          r_walk_active, n_walk_active;

    logic              r_out_valid;
    logic [CW-1:0]     r_out_offset, n_out_offset;
    logic [CW-1:0]     r_out_cluster, n_out_cluster;
    fce_pkg::t_outcome r_out_code, n_out_code;

    logic                         w_adv;
    logic                         w_has_res;
    logic [CW-1:0]                w_v;
    logic [CW-1:0]                w_wc;
    logic [CW-1:0]                w_cs;
    logic [CW-1:0]                w_rso;
    logic [CW-1:0]                w_rsc;
    logic                         w_is_bad;
    logic                         w_is_end;
    logic                         w_is_next;
    logic                         w_short;
    logic [fce_pkg::COVER_W-1:0]  w_covered;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    assign w_v   = r_in_entry[CW-1:0];
    assign w_wc  = r_walk_active ? r_walk_cluster  : r_start_cluster;
    assign w_cs  = r_walk_active ? r_clusters_seen : CW'(1);
    assign w_rso = r_walk_active ? r_run_offset    : '0;
    assign w_rsc = r_walk_active ? r_run_cluster   : r_start_cluster;

    assign w_is_bad  = (w_v == CW'(0)) || (w_v == CW'(1)) || (w_v == fce_pkg::bad_value(r_fat_kind));
    assign w_is_end  = (w_v >= fce_pkg::end_value(r_fat_kind));
    assign w_is_next = ({1'b0, w_v} == ({1'b0, w_wc} + (CW+1)'(1)));
    assign w_covered = fce_pkg::COVER_W'(w_cs) << r_log2;
    assign w_short   = (w_covered < fce_pkg::COVER_W'(r_file_bytes));

    always_comb begin
        n_walk_cluster  = w_wc;
        n_clusters_seen = w_cs;
        n_run_offset    = w_rso;
        n_run_cluster   = w_rsc;
        n_walk_active   = 1'b0;
        n_out_offset    = w_rso;
        n_out_cluster   = w_rsc;
        n_out_code      = fce_pkg::OUT_RUN;
        w_has_res       = 1'b1;
        priority if (w_is_bad) begin
            n_out_offset = '0;
            n_out_cluster = '0;
            n_out_code = fce_pkg::OUT_BADENTRY;
        end else if (w_is_end) begin
            if (w_short) begin
                n_out_offset = '0;
                n_out_cluster = '0;
                n_out_code = fce_pkg::OUT_SHORT;
            end else begin
                n_out_code = fce_pkg::OUT_FINAL;
            end
        end else begin
            n_walk_active  = 1'b1;
            n_walk_cluster = w_v;
            w_has_res      = !w_is_next;
            if (!w_is_next) begin
                n_run_offset  = w_cs;
                n_run_cluster = w_v;
            end
            if (w_cs < fce_pkg::CLU_MAX) begin
                n_clusters_seen = w_cs + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fat_kind      <= fce_pkg::KIND_RESET;
            r_start_cluster <= fce_pkg::START_RESET;
            r_file_bytes    <= fce_pkg::SIZE_RESET;
            r_log2          <= fce_pkg::LOG2_RESET;
        end else if (i_cfg_we) begin
            unique case (fce_pkg::t_reg_idx'(i_cfg_idx))
                fce_pkg::REG_FAT_KIND:      r_fat_kind      <= i_cfg_wdata[fce_pkg::KIND_W-1:0];
                fce_pkg::REG_START_CLUSTER: r_start_cluster <= i_cfg_wdata[CW-1:0];
                fce_pkg::REG_FILE_BYTES:    r_file_bytes    <= i_cfg_wdata[fce_pkg::SIZE_W-1:0];
                fce_pkg::REG_CLUSTER_LOG2:  r_log2          <= i_cfg_wdata[fce_pkg::LOG2_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_entry <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_active   <= 1'b0;
            r_clusters_seen <= CW'(1);
            r_walk_cluster  <= '0;
            r_run_offset    <= '0;
            r_run_cluster   <= '0;
        end else if (w_adv) begin
            r_walk_active   <= n_walk_active;
            r_clusters_seen <= n_clusters_seen;
            r_walk_cluster  <= n_walk_cluster;
            r_run_offset    <= n_run_offset;
            r_run_cluster   <= n_run_cluster;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_has_res;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_has_res) begin
            r_out_offset  <= n_out_offset;
            r_out_cluster <= n_out_cluster;
            r_out_code    <= n_out_code;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_cluster, r_out_offset};
    assign o_m_axis_tuser  = r_out_code;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_code == fce_pkg::OUT_BADENTRY || r_out_code == fce_pkg::OUT_SHORT)
        |-> (r_out_offset == '0) && (r_out_cluster == '0))
        else $error("error result carries non-zero run fields");

    a_end_stops_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (w_is_bad || w_is_end) |=> !r_walk_active && r_out_valid)
        else $error("terminating entry left walk active or gave no result");

    a_seen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clusters_seen != '0)
        else $error("cluster counter reached zero");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_entry))
        else $error("input word lost while stalled");

    a_link_keeps_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !w_is_bad && !w_is_end |=> r_walk_active && (r_walk_cluster == $past(w_v)))
        else $error("link entry did not advance the walk");

endmodule

>>> tb/sv/fat_chain_extent_builder_top_test.sv
// Testbench for the FAT chain extent builder: directed and random chain walks checked per word.
module fat_chain_extent_builder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 1000;

    typedef struct packed {
        logic [fce_pkg::CLU_W-1:0] offset;
        logic [fce_pkg::CLU_W-1:0] cluster;
        fce_pkg::t_outcome         outcome;
    } t_extent;

    typedef enum int {
        STEP_EXTEND,
        STEP_JUMP,
        STEP_END,
        STEP_BAD,
        STEP_FREE,
        STEP_RESERVED,
        STEP_NOISE
    } t_step;

    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       i_cfg_we        = 1'b0;
    logic [fce_pkg::IDX_W-1:0]  i_cfg_idx       = '0;
    logic [fce_pkg::CFG_W-1:0]  i_cfg_wdata     = '0;
    logic                       i_s_axis_tvalid = 1'b0;
    logic                       o_s_axis_tready;
    logic [31:0]                i_s_axis_tdata  = '0;  // [31:0] table_entry
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready = 1'b0;
    logic [55:0]                o_m_axis_tdata;        // [27:0] run_offset, [55:28] run_cluster
    logic [1:0]                 o_m_axis_tuser;        // [1:0] outcome

    fat_chain_extent_builder_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    int send_idle_pct = 34;
    int recv_idle_pct = 50;
    bit failed = 1'b0;
    int quiet_cycles = 0;

    t_extent pending_extents[$];

    logic [fce_pkg::KIND_W-1:0] kind_reg  = fce_pkg::KIND_RESET;
    logic [fce_pkg::CLU_W-1:0]  start_reg = fce_pkg::START_RESET;
    logic [fce_pkg::SIZE_W-1:0] bytes_reg = fce_pkg::SIZE_RESET;
    logic [fce_pkg::LOG2_W-1:0] log2_reg  = fce_pkg::LOG2_RESET;

    logic [fce_pkg::CLU_W-1:0]  cur_cluster = '0;
    logic [fce_pkg::CLU_W-1:0]  seen_count  = 28'd1;
    logic [fce_pkg::CLU_W-1:0]  ext_offset  = '0;
    logic [fce_pkg::CLU_W-1:0]  ext_cluster = '0;
    bit                         in_walk     = 1'b0;

    function automatic logic [fce_pkg::CLU_W-1:0] chain_end_code(
        input logic [fce_pkg::KIND_W-1:0] kind);
        case (kind)
            fce_pkg::KIND_FAT12: return 28'h000_0FF8;
            fce_pkg::KIND_FAT16: return 28'h000_FFF8;
            default:             return 28'hFFF_FFF8;
        endcase
    endfunction

    task automatic advance_chain(input logic [31:0] entry);
        logic [fce_pkg::CLU_W-1:0] link;
        logic [fce_pkg::CLU_W-1:0] eoc;
        logic [63:0]               covered;
        link = entry[fce_pkg::CLU_W-1:0];
        eoc  = chain_end_code(kind_reg);
        if (!in_walk) begin
            cur_cluster = start_reg;
            ext_cluster = start_reg;
            ext_offset  = '0;
            seen_count  = 28'd1;
            in_walk     = 1'b1;
        end
        if (link == 28'd0 || link == 28'd1 || link == eoc - 28'd1) begin
            in_walk = 1'b0;
            pending_extents.push_back('{offset: '0, cluster: '0,
                                        outcome: fce_pkg::OUT_BADENTRY});
        end else if (link >= eoc) begin
            covered = 64'(seen_count) << log2_reg;
            in_walk = 1'b0;
            if (covered < 64'(bytes_reg))
                pending_extents.push_back('{offset: '0, cluster: '0,
                                            outcome: fce_pkg::OUT_SHORT});
            else
                pending_extents.push_back('{offset: ext_offset, cluster: ext_cluster,
                                            outcome: fce_pkg::OUT_FINAL});
        end else begin
            if ({1'b0, link} != {1'b0, cur_cluster} + 29'd1) begin
                pending_extents.push_back('{offset: ext_offset, cluster: ext_cluster,
                                            outcome: fce_pkg::OUT_RUN});
                ext_offset  = seen_count;
                ext_cluster = link;
            end
            cur_cluster = link;
            if (seen_count != fce_pkg::CLU_MAX)
                seen_count = seen_count + 28'd1;
        end
    endtask

    function automatic logic [31:0] make_entry(input t_step step);
        logic [fce_pkg::CLU_W-1:0] eoc;
        logic [fce_pkg::CLU_W-1:0] from;
        logic [fce_pkg::CLU_W-1:0] link;
        eoc  = chain_end_code(kind_reg);
        from = in_walk ? cur_cluster : start_reg;
        case (step)
            STEP_EXTEND:   link = from + 28'd1;
            STEP_JUMP:     link = 28'($urandom_range(eoc - 28'd2, 2));
            STEP_END:      link = ($urandom_range(3) == 0) ? eoc
                                  : 28'($urandom_range(fce_pkg::CLU_MAX, eoc));
            STEP_BAD:      link = eoc - 28'd1;
            STEP_FREE:     link = 28'd0;
            STEP_RESERVED: link = 28'd1;
            default:       return $urandom;
        endcase
        return {4'($urandom), link};
    endfunction

    task automatic send_entry(input logic [31:0] entry);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= entry;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        advance_chain(entry);
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_extents.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input fce_pkg::t_reg_idx idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            fce_pkg::REG_FAT_KIND:      kind_reg  = value[fce_pkg::KIND_W-1:0];
            fce_pkg::REG_START_CLUSTER: start_reg = value[fce_pkg::CLU_W-1:0];
            fce_pkg::REG_FILE_BYTES:    bytes_reg = value;
            fce_pkg::REG_CLUSTER_LOG2:  log2_reg  = value[fce_pkg::LOG2_W-1:0];
            default: ;
        endcase
    endtask

    task automatic randomise_config();
        logic [fce_pkg::KIND_W-1:0] kind;
        logic [fce_pkg::CLU_W-1:0]  start;
        logic [fce_pkg::LOG2_W-1:0] log2;
        logic [31:0]                bytes;
        logic [fce_pkg::CLU_W-1:0]  eoc;
        kind = fce_pkg::KIND_W'($urandom_range(3));
        eoc  = chain_end_code(kind);
        case ($urandom_range(5))
            0:       start = 28'd2;
            1:       start = 28'($urandom_range(1));
            2:       start = fce_pkg::CLU_MAX - 28'($urandom_range(20));
            default: start = 28'($urandom_range(eoc - 28'd20, 2));
        endcase
        case ($urandom_range(5))
            0:       log2 = 5'd9;
            1:       log2 = 5'd25;
            2:       log2 = 5'($urandom_range(31));
            default: log2 = 5'($urandom_range(25, 9));
        endcase
        case ($urandom_range(5))
            0:       bytes = 32'd0;
            1:       bytes = 32'hFFFF_FFFF;
            2:       bytes = $urandom;
            default: bytes = (32'($urandom_range(12)) << log2) - 32'($urandom_range(1));
        endcase
        cfg_write(fce_pkg::REG_FAT_KIND, {30'($urandom), kind});
        cfg_write(fce_pkg::REG_START_CLUSTER, {4'($urandom), start});
        cfg_write(fce_pkg::REG_FILE_BYTES, bytes);
        cfg_write(fce_pkg::REG_CLUSTER_LOG2, {27'($urandom), log2});
    endtask

    task automatic test_reset_values();
        send_entry(32'h0000_0003);
        send_entry(32'h0000_0010);
        send_entry(32'hF000_0011);
        send_entry(32'hFFFF_FFFF);
    endtask

    task automatic test_fat_kinds();
        fce_pkg::t_fat_kind kind;
        kind = kind.first();
        repeat (4) begin
            settle();
            cfg_write(fce_pkg::REG_FAT_KIND, 32'(kind));
            send_entry(make_entry(STEP_BAD));
            send_entry({4'h0, chain_end_code(kind)});
            kind = kind.next();
        end
    endtask

    task automatic test_free_and_reserved();
        send_entry(32'hF000_0000);
        send_entry(32'h0000_0001);
    endtask

    task automatic test_size_compare();
        settle();
        cfg_write(fce_pkg::REG_FAT_KIND, 32'(fce_pkg::KIND_FAT32));
        cfg_write(fce_pkg::REG_FILE_BYTES, 32'hFFFF_FFFF);
        cfg_write(fce_pkg::REG_CLUSTER_LOG2, 32'd25);
        send_entry(make_entry(STEP_END));
        settle();
        cfg_write(fce_pkg::REG_CLUSTER_LOG2, 32'd31);
        send_entry(make_entry(STEP_EXTEND));
        send_entry(make_entry(STEP_END));
    endtask

    task automatic test_start_extremes();
        settle();
        cfg_write(fce_pkg::REG_FILE_BYTES, 32'd0);
        cfg_write(fce_pkg::REG_CLUSTER_LOG2, 32'd12);
        cfg_write(fce_pkg::REG_START_CLUSTER, 32'd0);
        send_entry(make_entry(STEP_END));
        settle();
        cfg_write(fce_pkg::REG_START_CLUSTER, 32'd1);
        send_entry(make_entry(STEP_END));
        settle();
        cfg_write(fce_pkg::REG_START_CLUSTER, 32'h0FFF_FFFF);
        send_entry(make_entry(STEP_END));
    endtask

    task automatic test_random_chains(input int items);
        int sent;
        int links;
        int pick;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(7) == 0) begin
                settle();
                randomise_config();
            end else if ($urandom_range(15) == 0) begin
                settle();
            end
            links = $urandom_range(12);
            repeat (links) begin
                if ($urandom_range(19) == 0)
                    send_entry(make_entry(STEP_NOISE));
                else
                    send_entry(make_entry($urandom_range(3) == 0 ? STEP_JUMP : STEP_EXTEND));
            end
            pick = $urandom_range(19);
            if (pick < 15)
                send_entry(make_entry(STEP_END));
            else if (pick == 15)
                send_entry(make_entry(STEP_BAD));
            else if (pick == 16)
                send_entry(make_entry(STEP_FREE));
            else if (pick == 17)
                send_entry(make_entry(STEP_RESERVED));
            else
                send_entry(make_entry(STEP_NOISE));
            sent += links + 1;
        end
    endtask

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_extent
        t_extent want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_extents.size() == 0) begin
                $display("%0t: unexpected word expected none actual %h/%h/%0d", $realtime,
                         o_m_axis_tdata[27:0], o_m_axis_tdata[55:28], o_m_axis_tuser);
                failed = 1'b1;
            end else begin
                want = pending_extents.pop_front();
                if (o_m_axis_tdata[27:0] !== want.offset) begin
                    $display("%0t: run_offset expected %h actual %h", $realtime,
                             want.offset, o_m_axis_tdata[27:0]);
                    failed = 1'b1;
                end
                if (o_m_axis_tdata[55:28] !== want.cluster) begin
                    $display("%0t: run_cluster expected %h actual %h", $realtime,
                             want.cluster, o_m_axis_tdata[55:28]);
                    failed = 1'b1;
                end
                if (o_m_axis_tuser !== want.outcome) begin
                    $display("%0t: outcome expected %0d actual %0d", $realtime,
                             want.outcome, o_m_axis_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                     || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 50;
        test_reset_values();
        test_fat_kinds();
        test_free_and_reserved();
        test_size_compare();
        test_start_extremes();
        test_random_chains(150);

        send_idle_pct = 50;
        recv_idle_pct = 34;
        test_random_chains(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_chains(150);

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (!failed && pending_extents.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
